@@ hw/rtl/sdl_pkg.sv @@
// Shared types and defaults for the sorted descending list.
`default_nettype none

package sdl_pkg;

    // Default geometry
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_GET    = 2'd2,
        KIND_REMOVE = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_FULL           = 2'd1,
        ST_EMPTY_OR_RANGE = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // shift right from the insert point, load new value there
        logic rem;   // shift left from the removed position
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_descending_list.sv @@
// Top level of the sorted descending list: control, fill count, cell chain and result register.
//
//  Channel  Dir  Handshake             Payload
//  in       in   in_valid / in_ready   kind, value, index
//  out      out  out_valid / out_ready data, status, count
//
// All cells compare and shift in the accepting cycle and
// the result lands in the output register on the same edge.
// in_ready is high while the output register is empty or being drained this cycle,
// so a stalled result holds off the next transaction.
// Reset clears the fill count and output valid only; entry contents need no clearing
// since only slots below the fill count are ever read.
`default_nettype none

module sorted_descending_list #(
    parameter int CAPACITY    = sdl_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sdl_pkg::VALUE_WIDTH_DEF,
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire sdl_pkg::kind_t                kind,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic [IDX_W-1:0]              index,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0]      data,
    output sdl_pkg::status_t                   status,
    output logic [CNT_W-1:0]                   count
);
    import sdl_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                          accept;
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [VALUE_WIDTH-1:0] data_reg;
    logic signed [VALUE_WIDTH-1:0] data_next;
    status_t                       status_reg;
    status_t                       status_next;
    logic [CNT_W-1:0]              count_reg;

    logic                          full;
    logic                          empty;
    logic                          idx_ok;
    logic [IDX_W-1:0]              rd_idx;
    logic [VALUE_WIDTH-1:0]        rd_or;
    cell_ctl_t                     ctl;

    logic                          gt_chain  [CAPACITY+1];
    logic signed [VALUE_WIDTH-1:0] ent_chain [CAPACITY+2];
    logic [VALUE_WIDTH-1:0]        rd_bus    [CAPACITY];

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    assign full   = (fill_reg == CAP_C);
    assign empty  = (fill_reg == '0);
    assign idx_ok = (CNT_W'(index) < fill_reg);

    // Pop reads the last occupied slot, get reads the requested one
    assign rd_idx = (kind == KIND_POP) ? IDX_W'(fill_reg - 1'b1) : index;

    // Chain ends: the first cell loads the new value, the last cell refills with itself
    assign gt_chain[0]           = 1'b1;
    assign ent_chain[0]          = value;
    assign ent_chain[CAPACITY+1] = ent_chain[CAPACITY];

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sdl_cell #(
            .CAPACITY    (CAPACITY),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CELL_IDX    (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .value       (value),
            .index       (index),
            .rd_idx      (rd_idx),
            .fill        (fill_reg),
            .left_gt     (gt_chain[i]),
            .left_entry  (ent_chain[i]),
            .right_entry (ent_chain[i+2]),
            .gt          (gt_chain[i+1]),
            .entry       (ent_chain[i+1]),
            .rd_data     (rd_bus[i])
        );
    end

    // Read bus: at most one cell drives nonzero
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | rd_bus[i];
        end
    end

    // Operation decode
    always_comb
    begin
        ctl         = '0;
        fill_next   = fill_reg;
        status_next = ST_OK;
        data_next   = '0;
        unique case (kind)
            KIND_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.ins   = accept;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY_OR_RANGE;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                    data_next = rd_or;
                end
            end
            KIND_GET:
            begin
                if (!idx_ok)
                begin
                    status_next = ST_EMPTY_OR_RANGE;
                end
                else
                begin
                    data_next = rd_or;
                end
            end
            KIND_REMOVE:
            begin
                if (!idx_ok)
                begin
                    status_next = ST_EMPTY_OR_RANGE;
                end
                else
                begin
                    ctl.rem   = accept;
                    fill_next = fill_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            count_reg  <= fill_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // Fill count never passes capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP_C)
        else $error("fill count above capacity");

    // Every transaction produces a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction gave no result");

    // Insert into a full list reports full and leaves the count alone
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == KIND_INSERT) && full
        |=> (status_reg == ST_FULL) && (fill_reg == $past(fill_reg)))
        else $error("insert on full list mishandled");

    // Reported count matches the stored fill count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg == fill_reg))
        else $error("reported count differs from fill count");

endmodule

`default_nettype wire

@@ hw/rtl/sdl_cell.sv @@
// One list slot: holds an entry, compares it against the incoming value, shifts with neighbors.
`default_nettype none

module sdl_cell #(
    parameter int CAPACITY    = sdl_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sdl_pkg::VALUE_WIDTH_DEF,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire sdl_pkg::cell_ctl_t            ctl,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic [IDX_W-1:0]              index,
    input  wire logic [IDX_W-1:0]              rd_idx,
    input  wire logic [CNT_W-1:0]              fill,
    input  wire logic                          left_gt,
    input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
    input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
    output logic                               gt,
    output logic signed [VALUE_WIDTH-1:0]      entry,
    output logic [VALUE_WIDTH-1:0]             rd_data
);
    import sdl_pkg::*;

    localparam logic [CNT_W-1:0] POS_C = CNT_W'(CELL_IDX);
    localparam logic [IDX_W-1:0] POS_I = IDX_W'(CELL_IDX);

    logic signed [VALUE_WIDTH-1:0] entry_reg;
    logic signed [VALUE_WIDTH-1:0] entry_next;
    logic                          occupied;

    // Strictly-greater flag, only meaningful for occupied slots
    assign occupied = (POS_C < fill);
    assign gt       = occupied && (entry_reg > value);
    assign entry    = entry_reg;

    // Read contribution for the OR-combined read bus
    assign rd_data = (rd_idx == POS_I) ? entry_reg : '0;

    // Insert: slots at or past the insert point take value or left neighbor.
    // Remove: slots at or past the index take the right neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && !gt)
        begin
            entry_next = left_gt ? value : left_entry;
        end
        else if (ctl.rem && (POS_I >= index))
        begin
            entry_next = right_entry;
        end
    end

    // Payload register, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ sim/tb_sorted_descending_list.sv @@
// Self-checking testbench for the sorted descending list: scoreboard, stimulus and result checks.
`default_nettype none

module tb_sorted_descending_list;

    import sdl_pkg::*;

    localparam int CAP         = sdl_pkg::CAPACITY_DEF;
    localparam int VW          = sdl_pkg::VALUE_WIDTH_DEF;
    localparam int IW          = $clog2(CAP);
    localparam int CW          = $clog2(CAP + 1);
    localparam int NUM_ITEMS   = 450;
    localparam int QUIET_FROM  = 400;   // no idling on either side from here on
    localparam int MID_PAUSE   = 250;   // sender waits for every result here
    localparam int HOLD_AT     = 120;   // receiver starts its long hold-off here
    localparam int LONG_HOLD   = 150;
    localparam int STALL_LIMIT = 1000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic signed [VW-1:0] data;
        status_t              status;
        logic [CW-1:0]        count;
    } list_result_t;

    // Shadow copy of the list plus the queue of results still owed by the block
    class sorted_list_scoreboard;
        logic signed [VW-1:0] slots [CAP];
        int unsigned          held;
        list_result_t         pending [$];
        int unsigned          mismatches;
        int unsigned          checked;
        int unsigned          op_seen [4];
        int unsigned          full_rejects;
        int unsigned          range_rejects;
        int unsigned          peak;

        function new();
            held          = 0;
            mismatches    = 0;
            checked       = 0;
            full_rejects  = 0;
            range_rejects = 0;
            peak          = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        // Apply one accepted transaction to the shadow list and queue its result
        function void note_input(kind_t k, logic signed [VW-1:0] v, logic [IW-1:0] idx);
            list_result_t r;
            int unsigned  pos;
            r.data   = '0;
            r.status = ST_OK;
            op_seen[int'(k)]++;
            case (k)
                KIND_INSERT:
                begin
                    if (held >= CAP)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        // new value lands after every strictly greater entry
                        pos = 0;
                        for (int i = 0; i < held; i++)
                            if (slots[i] > v) pos++;
                        for (int i = held; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = v;
                        held++;
                    end
                end
                KIND_POP:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY_OR_RANGE;
                    end
                    else
                    begin
                        held--;
                        r.data = slots[held];
                    end
                end
                KIND_GET:
                begin
                    if (idx >= held) r.status = ST_EMPTY_OR_RANGE;
                    else             r.data   = slots[idx];
                end
                default:
                begin
                    if (idx >= held)
                    begin
                        r.status = ST_EMPTY_OR_RANGE;
                    end
                    else
                    begin
                        for (int i = idx; i + 1 < held; i++)
                            slots[i] = slots[i + 1];
                        held--;
                    end
                end
            endcase
            if (r.status == ST_FULL)           full_rejects++;
            if (r.status == ST_EMPTY_OR_RANGE) range_rejects++;
            if (held > peak) peak = held;
            r.count = CW'(held);
            pending.push_back(r);
        endfunction

        // Compare one accepted result against the oldest owed result
        function void check_result(logic signed [VW-1:0] d, status_t s, logic [CW-1:0] c);
            list_result_t exp_r;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected result data=%0d status=%0d count=%0d",
                             d, s, c);
                return;
            end
            exp_r = pending.pop_front();
            if (d !== exp_r.data || s !== exp_r.status || c !== exp_r.count)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display({"ERROR: result %0d: expected data=%0d status=%0d count=%0d,",
                              " got data=%0d status=%0d count=%0d"},
                             checked, exp_r.data, exp_r.status, exp_r.count, d, s, c);
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    kind_t                kind      = KIND_INSERT;
    logic signed [VW-1:0] value     = '0;
    logic [IW-1:0]        index     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [VW-1:0] data;
    status_t              status;
    logic [CW-1:0]        count;

    sorted_list_scoreboard sb;
    int unsigned           items_sent = 0;

    sorted_descending_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (data),
        .status    (status),
        .count     (count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one transaction and hold it until the block takes it
    task automatic send_op(kind_t k, logic signed [VW-1:0] v, logic [IW-1:0] idx);
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        index    <= idx;
        do @(posedge clk); while (!in_ready);
        sb.note_input(k, v, idx);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Send, then maybe pause or leave a gap before the next transaction
    task automatic issue(kind_t k, logic signed [VW-1:0] v, logic [IW-1:0] idx);
        send_op(k, v, idx);
        if (items_sent == MID_PAUSE)
        begin
            settle();
        end
        else if (items_sent < QUIET_FROM && !(items_sent >= 150 && items_sent < 200)
                 && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Small values four times in ten so duplicates are common, plus extremes and full-range values
    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 16)) - 8;
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       return {1'b0, {(VW-1){1'b1}}};
                    1:       return {1'b1, {(VW-1){1'b0}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return VW'($urandom);
        endcase
    endfunction

    // Mostly a valid position, sometimes exactly one past the end, sometimes anything
    function automatic logic [IW-1:0] pick_index();
        int unsigned q;
        q = $urandom_range(0, 9);
        if (sb.held != 0 && q < 7) return IW'($urandom_range(0, sb.held - 1));
        if (q == 7) return IW'(sb.held);
        return IW'($urandom_range(0, CAP - 1));
    endfunction

    // Fill to capacity, then push against the full list
    task automatic fill_up();
        while (sb.held < CAP)
        begin
            if ($urandom_range(0, 6) == 0 && sb.held != 0)
                issue(KIND_GET, VW'($urandom), pick_index());
            else
                issue(KIND_INSERT, pick_value(), IW'($urandom));
        end
        issue(KIND_GET, VW'($urandom), IW'(CAP - 1));
        repeat ($urandom_range(1, 3)) issue(KIND_INSERT, pick_value(), IW'($urandom));
    endtask

    // Empty the list, then hit it while empty
    task automatic drain_out();
        int unsigned r;
        while (sb.held != 0)
        begin
            r = $urandom_range(0, 19);
            if (r < 10)      issue(KIND_POP, VW'($urandom), IW'($urandom));
            else if (r < 17) issue(KIND_REMOVE, VW'($urandom), IW'($urandom_range(0, sb.held - 1)));
            else             issue(KIND_GET, VW'($urandom), IW'($urandom_range(0, sb.held - 1)));
        end
        issue(KIND_POP, VW'($urandom), IW'($urandom));
        issue(KIND_GET, VW'($urandom), IW'($urandom_range(0, CAP - 1)));
        issue(KIND_REMOVE, VW'($urandom), IW'($urandom_range(0, CAP - 1)));
    endtask

    // Random mix of all four operations
    task automatic mixed_run();
        int unsigned r;
        int unsigned len;
        len = $urandom_range(10, 30);
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)      issue(KIND_INSERT, pick_value(), IW'($urandom));
            else if (r < 55) issue(KIND_POP, VW'($urandom), IW'($urandom));
            else if (r < 80) issue(KIND_GET, VW'($urandom), pick_index());
            else             issue(KIND_REMOVE, VW'($urandom), pick_index());
        end
    endtask

    // Stimulus: reset, directed cases, random chunks, then wind down
    initial
    begin : stimulus
        int unsigned chunk;
        int unsigned r;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: every read-type operation fails
        issue(KIND_POP,    '0, '0);
        issue(KIND_GET,    '0, '0);
        issue(KIND_REMOVE, '0, '0);
        issue(KIND_GET,    '1, '1);
        // extremes, duplicates and alternating bit patterns
        issue(KIND_INSERT, '0, '1);
        issue(KIND_INSERT, {1'b0, {(VW-1){1'b1}}}, '0);
        issue(KIND_INSERT, {1'b1, {(VW-1){1'b0}}}, '0);
        issue(KIND_INSERT, '1, '0);
        issue(KIND_INSERT, 1, '0);
        issue(KIND_INSERT, '0, '0);
        issue(KIND_INSERT, {(VW/2){2'b01}}, '0);
        issue(KIND_INSERT, {(VW/2){2'b10}}, '0);
        // reads at both ends and just past the end
        issue(KIND_GET, '0, '0);
        issue(KIND_GET, '0, IW'(7));
        issue(KIND_GET, '0, IW'(8));
        issue(KIND_GET, '0, '1);
        // removes in the middle, at the tail, past the end and at the head
        issue(KIND_REMOVE, '0, IW'(3));
        issue(KIND_REMOVE, '0, IW'(6));
        issue(KIND_REMOVE, '0, IW'(6));
        issue(KIND_REMOVE, '0, '0);
        issue(KIND_POP, '0, '0);
        issue(KIND_POP, '0, '0);
        issue(KIND_GET, '0, '0);
        settle();

        // random part: first a full fill and a full drain, then a random mix
        chunk = 0;
        while (items_sent < NUM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (chunk == 0 || r == 0)      fill_up();
            else if (chunk == 1 || r == 1) drain_out();
            else                           mixed_run();
            chunk++;
        end

        // wind down
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d inserts, %0d pops, %0d gets and %0d removes; peak fill %0d of %0d.",
                 sb.op_seen[KIND_INSERT], sb.op_seen[KIND_POP], sb.op_seen[KIND_GET],
                 sb.op_seen[KIND_REMOVE], sb.peak, CAP);
        $display("%0d inserts refused on a full list, %0d empty or bad-index requests; %0d results checked.",
                 sb.full_rejects, sb.range_rejects, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: check each transaction, stall in random bursts and once for a long stretch
    initial
    begin : result_sink
        int unsigned stall_left;
        bit          long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
                sb.check_result(data, status, count);
            if (!long_hold_done && sb.checked >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD;
            end
            else if (stall_left == 0 && sb.checked < QUIET_FROM
                     && !(sb.checked >= 300 && sb.checked < 340)
                     && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any transaction on either side
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else                                                    quiet_cycles++;
        end
        $display("ERROR: no transaction for %0d cycles, %0d results still owed",
                 STALL_LIMIT, sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
